// ----- rtl/tci_pkg.sv -----
`timescale 1ns / 1ps

package tci_pkg;

  localparam int StateW     = 18;
  localparam int CoefW      = 16;
  localparam int SampleW    = 16;
  localparam int OutW       = 11;
  localparam int NumStages  = 3;
  localparam int CfgIndexW  = 3;
  localparam int ProdW      = StateW + CoefW + 1;
  localparam int ProdShift  = 16;

  // Register indexes on the configuration channel
  localparam logic [CfgIndexW-1:0] RegPoleOne  = 3'd0;
  localparam logic [CfgIndexW-1:0] RegPoleTwo  = 3'd1;
  localparam logic [CfgIndexW-1:0] RegPoleThr  = 3'd2;
  localparam logic [CfgIndexW-1:0] RegZeroOne  = 3'd3;
  localparam logic [CfgIndexW-1:0] RegZeroTwo  = 3'd4;
  localparam logic [CfgIndexW-1:0] RegZeroThr  = 3'd5;

  typedef logic [StateW-1:0]         state_t;
  typedef logic [CoefW-1:0]          coef_t;
  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [OutW-1:0]    out_sample_t;
  typedef logic [CfgIndexW-1:0]      cfg_index_t;

  // Signed state times unsigned fraction, keep bits 33..16 (sign lands in bit 17)
  function automatic state_t coef_mul(input coef_t k, input state_t s);
    logic signed [ProdW-1:0] p;
    p = $signed(s) * $signed({1'b0, k});
    return p[ProdShift+StateW-1:ProdShift];
  endfunction

  // Drop three bits, fold bits 2 and 1 into bit 0, two's complement to 11 bits (sign from bit 17)
  function automatic out_sample_t narrow_out(input state_t d);
    logic [9:0] m;
    m = {d[11:3], d[2] | d[1]};
    if (!d[StateW-1]) begin
      return {1'b0, m};
    end else if (m == 10'd0) begin
      return '0;
    end else begin
      return {1'b1, m};
    end
  endfunction

endpackage

// ----- rtl/tci_in_if.sv -----
`timescale 1ns / 1ps

interface tci_in_if;
  logic             valid;
  logic             ready;
  tci_pkg::sample_t sample_in;
  logic             first_of_channel;

  modport source(output valid, output sample_in, output first_of_channel, input ready);
  modport sink(input valid, input sample_in, input first_of_channel, output ready);
endinterface

// ----- rtl/tci_out_if.sv -----
`timescale 1ns / 1ps

interface tci_out_if;
  logic                 valid;
  logic                 ready;
  tci_pkg::out_sample_t sample_out;

  modport source(output valid, output sample_out, input ready);
  modport sink(input valid, input sample_out, output ready);
endinterface

// ----- rtl/tci_cfg_if.sv -----
`timescale 1ns / 1ps

interface tci_cfg_if;
  logic                valid;
  logic                ready;
  tci_pkg::cfg_index_t index;
  tci_pkg::coef_t      data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// ----- rtl/tail_cancellation_iir_filter.sv -----
`timescale 1ns / 1ps

// Three cascaded pole-zero stages that cancel the slow tail of a pulse.
//
// in_if  : one request per sample (sample_in, first_of_channel). A request
//          with first_of_channel set clears all three stage states first.
// out_if : one request per input, sample_out as signed 11-bit value.
// cfg_if : register writes (index 0..5: pole one..three, zero one..three);
//          always ready, indexes above 5 are dropped. Write only when idle.
//
// An accepted input is held in the input register, then passes through the
// stage arithmetic into the output register. Throughput is one sample per
// clock while the receiver takes every output; the loop that sets it is
// the state feedback of each stage (one 18x17 multiply and the add chain).
// A stalled receiver holds the output register; the input register still
// takes one more request, then in_if.ready drops until the output drains.
// Reset (rst_n low, synchronous) empties both registers, zeroes the stage
// states and all six coefficients.
module tail_cancellation_iir_filter (
  input logic       clk,
  input logic       rst_n,
  tci_in_if.sink    in_if,
  tci_out_if.source out_if,
  tci_cfg_if.sink   cfg_if
);

  // Coefficients
  tci_pkg::coef_t pole_r [tci_pkg::NumStages];
  tci_pkg::coef_t zero_r [tci_pkg::NumStages];

  // Input register
  logic             in_valid_r;
  tci_pkg::sample_t sample_r;
  logic             first_r;

  // Stage states
  tci_pkg::state_t st_r   [tci_pkg::NumStages];
  tci_pkg::state_t st_nxt [tci_pkg::NumStages];

  // Output register
  logic                 out_valid_r;
  tci_pkg::out_sample_t out_sample_r;
  tci_pkg::out_sample_t out_sample_nxt;

  logic advance;
  logic fire;

  tci_pkg::state_t old_s   [tci_pkg::NumStages];
  tci_pkg::state_t stage_x [tci_pkg::NumStages+1];

  // Output register free, or being emptied this cycle
  assign advance = !out_valid_r || out_if.ready;
  assign fire    = in_valid_r && advance;

  assign in_if.ready       = !in_valid_r || advance;
  assign out_if.valid      = out_valid_r;
  assign out_if.sample_out = out_sample_r;
  assign cfg_if.ready      = 1'b1;

  // Stage arithmetic: products only on the old states, sums chain through
  always_comb begin
    stage_x[0] = {sample_r[tci_pkg::SampleW-1:0], 2'b00};
    for (int i = 0; i < tci_pkg::NumStages; i++) begin
      old_s[i]     = first_r ? '0 : st_r[i];
      st_nxt[i]    = stage_x[i] + tci_pkg::coef_mul(pole_r[i], old_s[i]);
      stage_x[i+1] = st_nxt[i] - tci_pkg::coef_mul(zero_r[i], old_s[i]);
    end
    out_sample_nxt = tci_pkg::narrow_out(stage_x[tci_pkg::NumStages]);
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < tci_pkg::NumStages; i++) begin
        pole_r[i] <= '0;
        zero_r[i] <= '0;
      end
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        tci_pkg::RegPoleOne: pole_r[0] <= cfg_if.data;
        tci_pkg::RegPoleTwo: pole_r[1] <= cfg_if.data;
        tci_pkg::RegPoleThr: pole_r[2] <= cfg_if.data;
        tci_pkg::RegZeroOne: zero_r[0] <= cfg_if.data;
        tci_pkg::RegZeroTwo: zero_r[1] <= cfg_if.data;
        tci_pkg::RegZeroThr: zero_r[2] <= cfg_if.data;
        default: ;
      endcase
    end
  end

  // Input register: take a request whenever the slot frees up
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      sample_r <= in_if.sample_in;
      first_r  <= in_if.first_of_channel;
    end
  end

  // Stage states: advance only when a sample moves into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < tci_pkg::NumStages; i++) begin
        st_r[i] <= '0;
      end
    end else if (fire) begin
      for (int i = 0; i < tci_pkg::NumStages; i++) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_sample_r <= out_sample_nxt;
    end
  end

  // An input taken into an empty block passes the input register, then the output register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready && !in_valid_r && !out_valid_r)
      |=> in_valid_r ##1 out_valid_r)
    else $error("accepted sample did not reach the output register in two cycles");

  // States hold unless a sample moves on
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> ($stable(st_r[0]) && $stable(st_r[1]) && $stable(st_r[2])))
    else $error("stage state changed without a sample advancing");

  // A write to pole one lands in its register
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_if.valid && cfg_if.index == tci_pkg::RegPoleOne)
      |=> pole_r[0] == $past(cfg_if.data))
    else $error("pole one coefficient not written");

  // A full pipeline with a stalled receiver holds its output sample
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && out_valid_r && !out_if.ready) |=> $stable(out_sample_r))
    else $error("output sample changed while stalled");

endmodule

// ----- bench/tci_checker.sv -----
`timescale 1ns / 1ps

module tci_checker
  import tci_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  tci_in_if           in_if,
  tci_out_if          out_if,
  tci_cfg_if          cfg_if,
  output int unsigned fail_count,
  output int unsigned pending
);

  coef_t       pole_k    [NumStages];
  coef_t       zero_l    [NumStages];
  state_t      stage_acc [NumStages];
  out_sample_t expected_outs [$];
  int unsigned outs_seen;

  // signed state times unsigned fraction, arithmetic shift, wrap to state width
  function automatic state_t scale_by(input coef_t c, input state_t s);
    longint prod;
    prod = longint'($signed(s)) * longint'(c);
    return state_t'(prod >>> ProdShift);
  endfunction

  function automatic out_sample_t round_to_out(input state_t d);
    logic [9:0] mag;
    logic [9:0] neg_mag;
    mag = {d[11:3], d[2] | d[1]};
    if (!d[StateW-1]) begin
      return {1'b0, mag};
    end
    neg_mag = 10'd0 - mag;
    return out_sample_t'(11'd0 - {1'b0, neg_mag});
  endfunction

  function automatic out_sample_t filter_sample(input sample_t x, input logic first);
    state_t d;
    state_t cn;
    if (first) begin
      foreach (stage_acc[s]) stage_acc[s] = '0;
    end
    d = {x, 2'b00};
    for (int s = 0; s < NumStages; s++) begin
      cn           = d + scale_by(pole_k[s], stage_acc[s]);
      d            = cn - scale_by(zero_l[s], stage_acc[s]);
      stage_acc[s] = cn;
    end
    return round_to_out(d);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] checker: %s", $realtime, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_sample_t want;
    if (!rst_n) begin
      foreach (stage_acc[s]) begin
        stage_acc[s] = '0;
        pole_k[s]    = '0;
        zero_l[s]    = '0;
      end
      expected_outs.delete();
      outs_seen = 0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          RegPoleOne: pole_k[0] = cfg_if.data;
          RegPoleTwo: pole_k[1] = cfg_if.data;
          RegPoleThr: pole_k[2] = cfg_if.data;
          RegZeroOne: zero_l[0] = cfg_if.data;
          RegZeroTwo: zero_l[1] = cfg_if.data;
          RegZeroThr: zero_l[2] = cfg_if.data;
          default: ;  // drop writes to unmapped indexes
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        expected_outs.push_back(filter_sample(in_if.sample_in, in_if.first_of_channel));
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_outs.size() == 0) begin
          report_mismatch($sformatf("output %0d: sample_out %0d with nothing expected",
                                    outs_seen, out_if.sample_out));
        end else begin
          want = expected_outs.pop_front();
          if (out_if.sample_out !== want) begin
            report_mismatch($sformatf("output %0d: sample_out %0d, expected %0d",
                                      outs_seen, out_if.sample_out, want));
          end
        end
        outs_seen++;
      end
    end
    pending = expected_outs.size();
  end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import tci_pkg::*;

  // Unmapped register indexes; writes there must leave the filter untouched
  localparam cfg_index_t  RegSpareLow    = 3'd6;
  localparam cfg_index_t  RegSpareHigh   = 3'd7;
  localparam int unsigned CycleLimit     = 400000;
  localparam int unsigned LongHoldCycles = 200;
  localparam int unsigned DrainCycles    = 8;
  localparam int unsigned RandomPhases   = 6;
  localparam int unsigned PhaseItems     = 105;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned pending;

  // Flags set by the stimulus; steady and long_hold_req also steer the receiver
  logic steady        = 1'b0;  // no idling on either side from here on
  logic sender_gaps   = 1'b0;
  logic long_hold_req = 1'b0;

  tci_in_if  in_ch ();
  tci_out_if out_ch ();
  tci_cfg_if cfg_ch ();

  tail_cancellation_iir_filter uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  tci_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_if     (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Offer one sample request; hold valid high on return so back-to-back
  // requests never lower and raise it within one step.
  task automatic send_sample(input sample_t smp, input logic first);
    int unsigned burst;
    if (sender_gaps && !steady && $urandom_range(0, 3) == 0) begin
      burst = $urandom_range(1, 19);
      in_ch.valid <= 1'b0;
      repeat (burst) @(negedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.sample_in        <= smp;
    in_ch.first_of_channel <= first;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input coef_t value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  // Write all six coefficients, with one write to a spare index slipped in
  task automatic load_coeffs(input coef_t pole [NumStages], input coef_t zero [NumStages]);
    write_reg(RegPoleOne, pole[0]);
    write_reg(RegPoleTwo, pole[1]);
    write_reg($urandom_range(0, 1) ? RegSpareLow : RegSpareHigh, coef_t'($urandom));
    write_reg(RegPoleThr, pole[2]);
    write_reg(RegZeroOne, zero[0]);
    write_reg(RegZeroTwo, zero[1]);
    write_reg(RegZeroThr, zero[2]);
    cfg_ch.valid <= 1'b0;
  endtask

  // Drop valid and wait until every expected sample has come back
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // Receiver: random stalls, one long hold-off on request, none in the tail
  initial begin : receiver
    int unsigned burst;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        // hold off long enough for the filter to back up into its input
        out_ch.ready <= 1'b0;
        repeat (LongHoldCycles) @(negedge clk);
        long_hold_req = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (!steady && $urandom_range(0, 11) == 0) begin
        burst = $urandom_range(1, 19);
        out_ch.ready <= 1'b0;
        repeat (burst) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    coef_t       k [NumStages];
    coef_t       l [NumStages];
    sample_t     smp;
    int unsigned left;
    int unsigned run_len;
    int unsigned pos;

    in_ch.valid            = 1'b0;
    in_ch.sample_in        = '0;
    in_ch.first_of_channel = 1'b0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.index           = RegPoleOne;
    cfg_ch.data            = '0;
    rst_n                  = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Coefficients at their reset value of zero: the output is the scaled
    // input alone, so this walks the narrowing, including a negative value
    // whose kept magnitude is zero (comes out as zero, never as -1024).
    sender_gaps = 1'b1;
    send_sample(16'sd0, 1'b1);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(-16'sd1024, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd511, 1'b0);
    send_sample(16'sd3, 1'b0);
    send_sample(-16'sd3, 1'b0);
    quiesce();

    // Full-scale feedback with nothing subtracted: drive the states round
    // the 18-bit wrap with repeated extremes.
    k = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
    l = '{16'h0000, 16'h0000, 16'h0000};
    load_coeffs(k, l);
    send_sample(16'sd32767, 1'b1);
    send_sample(16'sd32767, 1'b0);
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    quiesce();

    // Zero feedback with full-scale subtraction
    k = '{16'h0000, 16'h0000, 16'h0000};
    l = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
    load_coeffs(k, l);
    send_sample(16'sd32767, 1'b1);
    send_sample(-16'sd1, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    quiesce();

    // A pulse and its tail through realistic near-unity coefficients
    k = '{16'd58982, 16'd60000, 16'd62000};
    l = '{16'd61000, 16'd64000, 16'd65000};
    load_coeffs(k, l);
    send_sample(16'sd8000, 1'b1);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b0);
    quiesce();

    // Random phases: each a fresh coefficient set, then channels that open
    // with a pulse and run on with mixed samples.
    for (int phase = 0; phase < RandomPhases; phase++) begin
      for (int s = 0; s < NumStages; s++) begin
        case (phase)
          1: begin
            k[s] = $urandom_range(0, 1) ? '1 : '0;
            l[s] = $urandom_range(0, 1) ? '1 : '0;
          end
          2: begin
            k[s] = coef_t'($urandom_range(55000, 65535));
            l[s] = coef_t'($urandom_range(55000, 65535));
          end
          3: begin
            k[s] = ($urandom_range(0, 2) == 0) ? '0 : coef_t'($urandom);
            l[s] = ($urandom_range(0, 2) == 0) ? '0 : coef_t'($urandom);
          end
          default: begin
            k[s] = coef_t'($urandom);
            l[s] = coef_t'($urandom);
          end
        endcase
      end
      load_coeffs(k, l);
      if (phase == 2) long_hold_req = 1'b1;
      if (phase == RandomPhases - 1) steady = 1'b1;
      left = PhaseItems;
      while (left > 0) begin
        run_len     = $urandom_range(1, 40);
        sender_gaps = ($urandom_range(0, 2) != 0);
        for (pos = 0; pos < run_len && left > 0; pos++) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: smp = sample_t'($urandom);
            4, 5:       smp = sample_t'(int'($urandom_range(0, 1023)) - 512);
            6:          smp = '0;
            7:          smp = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default:    smp = (pos == 0) ? sample_t'($urandom) : sample_t'($urandom_range(0, 15));
          endcase
          // the odd restart mid-channel as well as at every channel start
          send_sample(smp, (pos == 0) || ($urandom_range(0, 31) == 0));
          left--;
        end
      end
      quiesce();
    end

    // Give the filter time to emit anything it should not
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
